FILE: sv/kmds_pkg.sv
// ----------------------------------------------------------------------------
// kmds_pkg
// Shared sizes, result type and a helper for the key matrix debounce scanner.
// ----------------------------------------------------------------------------
`default_nettype none

package kmds_pkg;

    localparam int NUM_ROWS  = 6;
    localparam int NUM_COLS  = 17;
    localparam int COL_W     = 5;
    localparam int COL_IDX_W = $clog2(NUM_COLS);
    localparam int CNT_W     = 8;
    localparam int KEY_W     = 7;
    localparam int PC_W      = $clog2(NUM_ROWS + 1);

    localparam logic [CNT_W-1:0] RELOAD_RESET = CNT_W'(5);

    typedef struct packed {
        logic [KEY_W-1:0]    key_count;
        logic                bounce_seen;
        logic                settled;
        logic                scan_done;
        logic [NUM_ROWS-1:0] stable_column;
    } result_t;

    function automatic logic [PC_W-1:0] pop_rows(input logic [NUM_ROWS-1:0] v);
        logic [PC_W-1:0] n;
        n = '0;
        for (int r = 0; r < NUM_ROWS; r++)
        begin
            n = n + PC_W'(v[r]);
        end
        return n;
    endfunction

endpackage

`default_nettype wire

FILE: sv/kmds_matrix.sv
// ----------------------------------------------------------------------------
// kmds_matrix
// Raw and stable key matrices, global debounce counter and running key counts.
// ----------------------------------------------------------------------------
`default_nettype none

module kmds_matrix
    import kmds_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                step,
    input  wire logic [COL_W-1:0]    column,
    input  wire logic [NUM_ROWS-1:0] row_bits,
    input  wire logic                cfg_we,
    input  wire logic [CNT_W-1:0]    cfg_data,
    output result_t                  res
);

    logic [NUM_ROWS-1:0] raw_reg    [NUM_COLS];
    logic [NUM_ROWS-1:0] stable_reg [NUM_COLS];
    logic [NUM_ROWS-1:0] raw_next   [NUM_COLS];
    logic [CNT_W-1:0]    count_reg;
    logic [CNT_W-1:0]    reload_reg;
    logic [KEY_W-1:0]    raw_keys_reg;
    logic [KEY_W-1:0]    stable_keys_reg;

    logic                 col_ok;
    logic [COL_IDX_W-1:0] idx;
    logic [NUM_ROWS-1:0]  old_raw;
    logic [NUM_ROWS-1:0]  diff;
    logic                 changed;
    logic                 last_col;
    logic                 commit;
    logic                 bounce;
    logic [CNT_W-1:0]     count_a;
    logic [CNT_W-1:0]     count_next;
    logic [KEY_W-1:0]     raw_keys_next;

    always_comb
    begin
        col_ok   = column < COL_W'(NUM_COLS);
        idx      = column[COL_IDX_W-1:0];
        old_raw  = raw_reg[idx];
        diff     = old_raw ^ row_bits;
        changed  = |diff;
        last_col = idx == COL_IDX_W'(NUM_COLS - 1);
        // a change while the counter still runs bounces; so does a multi-row change if the reload is non-zero
        bounce   = (changed && count_reg != '0) ||
                   (pop_rows(diff) > PC_W'(1) && reload_reg != '0);
        count_a  = changed ? reload_reg : count_reg;
        count_next = (last_col && count_a != '0) ? count_a - CNT_W'(1) : count_a;
        commit   = last_col && count_next == '0;
        raw_keys_next = raw_keys_reg + KEY_W'(pop_rows(row_bits)) - KEY_W'(pop_rows(old_raw));
        for (int c = 0; c < NUM_COLS; c++)
        begin
            raw_next[c] = (COL_IDX_W'(c) == idx) ? row_bits : raw_reg[c];
        end

        if (col_ok)
        begin
            res.stable_column = commit ? row_bits : stable_reg[idx];
            res.scan_done     = last_col;
            res.settled       = count_next == '0;
            res.bounce_seen   = bounce;
            res.key_count     = commit ? raw_keys_next : stable_keys_reg;
        end
        else
        begin
            res.stable_column = '0;
            res.scan_done     = 1'b0;
            res.settled       = count_reg == '0;
            res.bounce_seen   = 1'b0;
            res.key_count     = stable_keys_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int c = 0; c < NUM_COLS; c++)
            begin
                raw_reg[c]    <= '0;
                stable_reg[c] <= '0;
            end
            count_reg       <= RELOAD_RESET;
            reload_reg      <= RELOAD_RESET;
            raw_keys_reg    <= '0;
            stable_keys_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                reload_reg <= cfg_data;
            end
            if (step && col_ok)
            begin
                raw_reg[idx] <= row_bits;
                count_reg    <= count_next;
                raw_keys_reg <= raw_keys_next;
                if (commit)
                begin
                    for (int c = 0; c < NUM_COLS; c++)
                    begin
                        stable_reg[c] <= raw_next[c];
                    end
                    stable_keys_reg <= raw_keys_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

FILE: sv/key_matrix_debounce_scanner_top.sv
// ----------------------------------------------------------------------------
// key_matrix_debounce_scanner_top
// Column-sample stream in, debounced column status stream out.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one column sample per beat: column index and row bits.
//   m_axis returns one beat per sample: the stable rows of that column,
//   settled and bounce flags and the stable key count; tlast marks the
//   beat of the last column, which ends a scan.
//   cfg carries the debounce reload (scans of quiet before commit); it is
//   always ready and is meant to be written while the stream is idle.
// Timing:
//   The output beat follows the input beat in the next cycle. Throughput is
//   one beat per cycle while m_axis takes its beats: the matrix state updates
//   at the input beat and the result sits in a single output register.
// Reset:
//   Both matrices clear, counter and reload return to 5, output empties.
// Stall:
//   While the output register holds a beat that is not taken, s_axis_tready
//   drops; it rises again in the cycle the beat is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module key_matrix_debounce_scanner_top
    import kmds_pkg::*;
(
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    input  wire logic [15:0] s_axis_tdata,  // column[4:0], row_bits[10:5], zero fill
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    output logic [15:0]      m_axis_tdata,  // stable_column[5:0], settled[6],
                                            // bounce_seen[7], key_count[14:8], zero
    output logic             m_axis_tlast,  // scan_done
    input  wire logic        cfg_valid,
    output logic             cfg_ready,
    input  wire logic [7:0]  cfg_data
);

    logic    in_beat;
    logic    out_valid_reg;
    result_t res;
    result_t res_reg;

    assign s_axis_tready = !out_valid_reg || m_axis_tready;
    assign in_beat       = s_axis_tvalid && s_axis_tready;
    assign cfg_ready     = 1'b1;

    kmds_matrix u_matrix (
        .clk      (clk),
        .rst_n    (rst_n),
        .step     (in_beat),
        .column   (s_axis_tdata[COL_W-1:0]),
        .row_bits (s_axis_tdata[COL_W+NUM_ROWS-1:COL_W]),
        .cfg_we   (cfg_valid && cfg_ready),
        .cfg_data (cfg_data),
        .res      (res)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (s_axis_tready)
        begin
            out_valid_reg <= s_axis_tvalid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_beat)
        begin
            res_reg <= res;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tlast  = res_reg.scan_done;
    assign m_axis_tdata  = {1'b0, res_reg.key_count, res_reg.bounce_seen,
                            res_reg.settled, res_reg.stable_column};

`ifndef SYNTHESIS
    a_beat_lands: assert property (@(posedge clk) disable iff (!rst_n)
        in_beat |=> m_axis_tvalid)
        else $error("accepted sample produced no output beat");

    a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("input accepted while output stalled");

    a_key_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tdata[14:8] <= 7'(NUM_ROWS * NUM_COLS)))
        else $error("key count beyond matrix size");

    a_last_out_of_range: assert property (@(posedge clk) disable iff (!rst_n)
        (in_beat && s_axis_tdata[COL_W-1:0] >= COL_W'(NUM_COLS)) |=> !m_axis_tlast)
        else $error("ignored column flagged as scan end");
`endif

endmodule

`default_nettype wire
